// ----- design/stbc_pkg.sv -----
// Package for the sprite table box collision block.
// Holds the operation codes and the command and status bundles that join
// the controller to the datapath. Depends on nothing.
package stbc_pkg;

  // Widths of the request and result fields.
  localparam int FUNC_W = 2;
  localparam int SLOT_W = 6;
  localparam int IMG_W  = 6;
  localparam int POS_W  = 16;
  localparam int SIZE_W = 10;
  localparam int HOT_W  = 11;
  localparam int HIT_W  = 7;
  // Box corners: position minus hotspot, plus size, with headroom.
  localparam int BOX_W  = 18;

  // Operation codes carried in func.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_SET     = 2'd1,
    FUNC_OFF     = 2'd2,
    FUNC_COLLIDE = 2'd3
  } func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_write;
    logic set_write;
    logic off;
    logic scan_start;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  scan_done;
  } status_t;

endpackage

// ----- design/stbc_datapath.sv -----
// Datapath of the sprite table box collision block: request registers,
// descriptor and slot memories, and the pipelined collision scan.
// Depends on stbc_pkg.
module stbc_datapath #(
  parameter int NUM_SLOTS    = 64,
  parameter int NUM_IMAGES   = 64,
  parameter int DEFAULT_SIZE = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  stbc_pkg::cmd_t                     cmd,
  output stbc_pkg::status_t                  status,
  input  logic [stbc_pkg::FUNC_W-1:0]        func,
  input  logic [stbc_pkg::SLOT_W-1:0]        slot,
  input  logic                               all_slots,
  input  logic signed [stbc_pkg::POS_W-1:0]  pos_x,
  input  logic signed [stbc_pkg::POS_W-1:0]  pos_y,
  input  logic [stbc_pkg::IMG_W-1:0]         image,
  input  logic [stbc_pkg::SIZE_W-1:0]        img_width,
  input  logic [stbc_pkg::SIZE_W-1:0]        img_height,
  input  logic signed [stbc_pkg::HOT_W-1:0]  img_hot_x,
  input  logic signed [stbc_pkg::HOT_W-1:0]  img_hot_y,
  output logic [stbc_pkg::HIT_W-1:0]         hit
);

  // Only slots and images that the request fields can address are stored.
  localparam int SLOT_MAX   = 1 << stbc_pkg::SLOT_W;
  localparam int IMG_MAX    = 1 << stbc_pkg::IMG_W;
  localparam int SLOT_DEPTH = (NUM_SLOTS < SLOT_MAX) ? NUM_SLOTS : SLOT_MAX;
  localparam int IMG_DEPTH  = (NUM_IMAGES < IMG_MAX) ? NUM_IMAGES : IMG_MAX;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int IMG_AW     = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int BW         = stbc_pkg::BOX_W;

  typedef struct packed {
    logic [stbc_pkg::SIZE_W-1:0]       width;
    logic [stbc_pkg::SIZE_W-1:0]       height;
    logic signed [stbc_pkg::HOT_W-1:0] hot_x;
    logic signed [stbc_pkg::HOT_W-1:0] hot_y;
  } desc_t;

  typedef struct packed {
    logic signed [stbc_pkg::POS_W-1:0] x;
    logic signed [stbc_pkg::POS_W-1:0] y;
  } slot_pos_t;

  typedef struct packed {
    logic [stbc_pkg::IMG_W-1:0]        image;
    logic signed [stbc_pkg::HOT_W-1:0] hot_x;
    logic signed [stbc_pkg::HOT_W-1:0] hot_y;
  } slot_img_t;

  // Request registers.
  stbc_pkg::func_t                   item_func;
  logic [stbc_pkg::SLOT_W-1:0]       item_slot;
  logic                              item_all;
  logic signed [stbc_pkg::POS_W-1:0] item_x;
  logic signed [stbc_pkg::POS_W-1:0] item_y;
  logic [stbc_pkg::IMG_W-1:0]        item_image;
  logic [stbc_pkg::SIZE_W-1:0]       item_w;
  logic [stbc_pkg::SIZE_W-1:0]       item_h;
  logic signed [stbc_pkg::HOT_W-1:0] item_hx;
  logic signed [stbc_pkg::HOT_W-1:0] item_hy;

  // Per-entry flags held in flip-flops.
  logic [SLOT_DEPTH-1:0] active;
  logic [SLOT_DEPTH-1:0] img_set;
  logic [IMG_DEPTH-1:0]  desc_valid;

  // Memories and their registered read data.
  desc_t     desc_mem [IMG_DEPTH];
  slot_pos_t pos_mem  [SLOT_DEPTH];
  slot_img_t img_mem  [SLOT_DEPTH];
  desc_t     desc_rd;
  slot_pos_t pos_rd;
  slot_img_t img_rd;

  // Scan issue control.
  logic               issuing;
  logic               issue_q;
  logic [SLOT_AW-1:0] issue_cnt;
  logic [SLOT_AW-1:0] scan_addr;

  // Scan pipeline stages.
  logic               s1_valid, s2_valid, s3_valid;
  logic               s1_query, s2_query, s3_query;
  logic [SLOT_AW-1:0] s1_idx, s2_idx, s3_idx;
  logic               s1_act, s2_act, s3_act;
  logic               s1_set;
  logic               s2_dv;
  logic signed [BW-1:0] s2_x1, s2_y1;
  logic signed [BW-1:0] s3_x1, s3_y1, s3_x2, s3_y2;

  // Query box and result of the scan.
  logic                       q_ok;
  logic signed [BW-1:0]       qa_x1, qa_y1, qa_x2, qa_y2;
  logic                       hit_found;
  logic [stbc_pkg::HIT_W-1:0] hit_val;

  // Decoded request fields.
  logic                        slot_ok;
  logic                        image_ok;
  logic [SLOT_AW-1:0]          slot_idx;
  logic [IMG_AW-1:0]           image_idx;
  logic                        set_dv;
  logic [IMG_AW-1:0]           desc_addr;

  // Stage one and two combinational values.
  logic [stbc_pkg::IMG_W-1:0]        s1_image;
  logic signed [stbc_pkg::HOT_W-1:0] s1_hx, s1_hy;
  logic signed [BW-1:0]              s1_x1, s1_y1;
  logic                              s1_dv;
  logic [stbc_pkg::SIZE_W-1:0]       s2_w, s2_h;
  logic signed [BW-1:0]              s2_x2, s2_y2;
  logic                              overlap;

  // Range checks and indices of the held request.
  assign slot_ok   = {1'b0, item_slot} < (stbc_pkg::SLOT_W+1)'(SLOT_DEPTH);
  assign image_ok  = {1'b0, item_image} < (stbc_pkg::IMG_W+1)'(IMG_DEPTH);
  assign slot_idx  = item_slot[SLOT_AW-1:0];
  assign image_idx = item_image[IMG_AW-1:0];
  assign set_dv    = image_ok && desc_valid[image_idx];

  // The query slot goes down the pipeline first, then every slot in order.
  assign scan_addr = issue_q ? slot_idx : issue_cnt;

  // Stage one: slot image with its reset value, and the box origin.
  assign s1_image = s1_set ? img_rd.image : '0;
  assign s1_hx    = s1_set ? img_rd.hot_x : '0;
  assign s1_hy    = s1_set ? img_rd.hot_y : '0;
  assign s1_x1    = {{(BW-stbc_pkg::POS_W){pos_rd.x[stbc_pkg::POS_W-1]}}, pos_rd.x}
                  - {{(BW-stbc_pkg::HOT_W){s1_hx[stbc_pkg::HOT_W-1]}}, s1_hx};
  assign s1_y1    = {{(BW-stbc_pkg::POS_W){pos_rd.y[stbc_pkg::POS_W-1]}}, pos_rd.y}
                  - {{(BW-stbc_pkg::HOT_W){s1_hy[stbc_pkg::HOT_W-1]}}, s1_hy};
  assign s1_dv    = ({1'b0, s1_image} < (stbc_pkg::IMG_W+1)'(IMG_DEPTH))
                  && desc_valid[s1_image[IMG_AW-1:0]];

  // The descriptor port serves the scan when it runs, the request otherwise.
  assign desc_addr = s1_valid ? s1_image[IMG_AW-1:0] : image_idx;

  // Stage two: size of the image, or the default size, gives the far corner.
  assign s2_w  = s2_dv ? desc_rd.width  : stbc_pkg::SIZE_W'(DEFAULT_SIZE);
  assign s2_h  = s2_dv ? desc_rd.height : stbc_pkg::SIZE_W'(DEFAULT_SIZE);
  assign s2_x2 = s2_x1 + {{(BW-stbc_pkg::SIZE_W){1'b0}}, s2_w};
  assign s2_y2 = s2_y1 + {{(BW-stbc_pkg::SIZE_W){1'b0}}, s2_h};

  // Stage three: overlap of the stage box with the query box.
  assign overlap = (qa_x1 < s3_x2) && (qa_x2 > s3_x1)
                && (qa_y1 < s3_y2) && (qa_y2 > s3_y1);

  // Capture the request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_func  <= stbc_pkg::func_t'(func);
      item_slot  <= slot;
      item_all   <= all_slots;
      item_x     <= pos_x;
      item_y     <= pos_y;
      item_image <= image;
      item_w     <= img_width;
      item_h     <= img_height;
      item_hx    <= img_hot_x;
      item_hy    <= img_hot_y;
    end
  end

  // Active, image-written and descriptor-valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      img_set    <= '0;
      desc_valid <= '0;
    end else begin
      if (cmd.load_write && image_ok) begin
        desc_valid[image_idx] <= 1'b1;
      end
      if (cmd.set_write && slot_ok) begin
        active[slot_idx] <= 1'b1;
        if (set_dv) begin
          img_set[slot_idx] <= 1'b1;
        end
      end
      if (cmd.off) begin
        if (item_all) begin
          active <= '0;
        end else if (slot_ok) begin
          active[slot_idx] <= 1'b0;
        end
      end
    end
  end

  // Descriptor memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load_write && image_ok) begin
      desc_mem[image_idx] <= {item_w, item_h, item_hx, item_hy};
    end
    desc_rd <= desc_mem[desc_addr];
  end

  // Slot memories: position always, image and hotspot only with a valid image.
  always_ff @(posedge clk) begin
    if (cmd.set_write && slot_ok) begin
      pos_mem[slot_idx] <= {item_x, item_y};
      if (set_dv) begin
        img_mem[slot_idx] <= {item_image, desc_rd.hot_x, desc_rd.hot_y};
      end
    end
    pos_rd <= pos_mem[scan_addr];
    img_rd <= img_mem[scan_addr];
  end

  // Scan control: issue pointer, stage valids, query flag and hit flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      issue_q   <= 1'b0;
      issue_cnt <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      q_ok      <= 1'b0;
      hit_found <= 1'b0;
    end else if (cmd.capture) begin
      issuing   <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      hit_found <= 1'b0;
    end else begin
      s1_valid <= issuing;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      if (cmd.scan_start) begin
        issuing   <= 1'b1;
        issue_q   <= 1'b1;
        issue_cnt <= '0;
        q_ok      <= 1'b0;
        hit_found <= 1'b0;
      end else begin
        if (issuing) begin
          if (issue_q) begin
            issue_q <= 1'b0;
          end else if (issue_cnt == SLOT_AW'(SLOT_DEPTH - 1)) begin
            issuing <= 1'b0;
          end else begin
            issue_cnt <= issue_cnt + SLOT_AW'(1);
          end
        end
        if (s3_valid && s3_query) begin
          q_ok <= slot_ok && s3_act;
        end
        if (s3_valid && !s3_query && q_ok && s3_act && (s3_idx != slot_idx)
            && overlap && !hit_found) begin
          hit_found <= 1'b1;
        end
      end
    end
  end

  // Scan pipeline payload, query box and hit index.
  always_ff @(posedge clk) begin
    s1_query <= issue_q;
    s1_idx   <= scan_addr;
    s1_act   <= active[scan_addr];
    s1_set   <= img_set[scan_addr];
    s2_query <= s1_query;
    s2_idx   <= s1_idx;
    s2_act   <= s1_act;
    s2_dv    <= s1_dv;
    s2_x1    <= s1_x1;
    s2_y1    <= s1_y1;
    s3_query <= s2_query;
    s3_idx   <= s2_idx;
    s3_act   <= s2_act;
    s3_x1    <= s2_x1;
    s3_y1    <= s2_y1;
    s3_x2    <= s2_x2;
    s3_y2    <= s2_y2;
    if (s3_valid && s3_query) begin
      qa_x1 <= s3_x1;
      qa_y1 <= s3_y1;
      qa_x2 <= s3_x2;
      qa_y2 <= s3_y2;
    end
    if (cmd.scan_start) begin
      hit_val <= '0;
    end else if (s3_valid && !s3_query && q_ok && s3_act && (s3_idx != slot_idx)
                 && overlap && !hit_found) begin
      hit_val <= stbc_pkg::HIT_W'(s3_idx) + stbc_pkg::HIT_W'(1);
    end
  end

  // Output register: the hit index for a collide request, zero otherwise.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit <= (item_func == stbc_pkg::FUNC_COLLIDE) ? hit_val : '0;
    end
  end

  assign status.func      = item_func;
  assign status.scan_done = hit_found
                          || (!issuing && !s1_valid && !s2_valid && !s3_valid);

`ifndef SYNTHESIS
  // A found hit always names a slot, so it is never zero.
  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    hit_found |-> (hit_val != '0))
    else $error("hit flagged with a zero slot number");

  // A hit is only recorded after the query slot was found active.
  a_hit_needs_query: assert property (@(posedge clk) disable iff (rst)
    hit_found |-> q_ok)
    else $error("hit recorded without a valid query slot");

  // The scan only runs for a collide request.
  a_scan_on_collide: assert property (@(posedge clk) disable iff (rst)
    issuing |-> (item_func == stbc_pkg::FUNC_COLLIDE))
    else $error("scan running for a request that is not a collide");

  // A hit never names the query slot itself.
  a_hit_not_self: assert property (@(posedge clk) disable iff (rst)
    hit_found |-> (hit_val != (stbc_pkg::HIT_W'(slot_idx) + stbc_pkg::HIT_W'(1))))
    else $error("hit names the query slot");
`endif

endmodule

// ----- design/stbc_ctrl.sv -----
// Controller of the sprite table box collision block: sequences each
// request through the datapath and owns the handshakes of both channels.
// Depends on stbc_pkg.
module stbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output stbc_pkg::cmd_t    cmd,
  input  stbc_pkg::status_t status
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DISPATCH = 5'b00010,
    ST_SET_WR   = 5'b00100,
    ST_SCAN     = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        // A set request reads its descriptor here and writes next cycle.
        case (status.func)
          stbc_pkg::FUNC_LOAD: begin
            cmd.load_write = 1'b1;
            state_next     = ST_FINISH;
          end
          stbc_pkg::FUNC_SET: begin
            state_next = ST_SET_WR;
          end
          stbc_pkg::FUNC_OFF: begin
            cmd.off    = 1'b1;
            state_next = ST_FINISH;
          end
          stbc_pkg::FUNC_COLLIDE: begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_SET_WR: begin
        cmd.set_write = 1'b1;
        state_next    = ST_FINISH;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Wait until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output valid follows the output register.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/sprite_table_box_collision_top.sv -----
// Load and off go from dispatch to the finish state; set adds a write state
// after its descriptor read; collide reads the query slot, then one slot read per
// cycle, through a three-stage compare pipeline; a hit ends it early.
// Only one request is in work at a time; a new one is accepted while a result
// still waits.
// Reset clears all slots and descriptors.
module sprite_table_box_collision_top #(
  parameter int NUM_SLOTS    = 64,
  parameter int NUM_IMAGES   = 64,
  parameter int DEFAULT_SIZE = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [stbc_pkg::FUNC_W-1:0]       func,
  input  logic [stbc_pkg::SLOT_W-1:0]       slot,
  input  logic                              all_slots,
  input  logic signed [stbc_pkg::POS_W-1:0] pos_x,
  input  logic signed [stbc_pkg::POS_W-1:0] pos_y,
  input  logic [stbc_pkg::IMG_W-1:0]        image,
  input  logic [stbc_pkg::SIZE_W-1:0]       img_width,
  input  logic [stbc_pkg::SIZE_W-1:0]       img_height,
  input  logic signed [stbc_pkg::HOT_W-1:0] img_hot_x,
  input  logic signed [stbc_pkg::HOT_W-1:0] img_hot_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [stbc_pkg::HIT_W-1:0]        hit
);

  stbc_pkg::cmd_t    cmd;
  stbc_pkg::status_t status;

  // Request sequencer.
  stbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Tables and collision scan.
  stbc_datapath #(
    .NUM_SLOTS    (NUM_SLOTS),
    .NUM_IMAGES   (NUM_IMAGES),
    .DEFAULT_SIZE (DEFAULT_SIZE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .func       (func),
    .slot       (slot),
    .all_slots  (all_slots),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .image      (image),
    .img_width  (img_width),
    .img_height (img_height),
    .img_hot_x  (img_hot_x),
    .img_hot_y  (img_hot_y),
    .hit        (hit)
  );

endmodule
